/* rtl/core/ffaa_pkg.sv */
// Shared types, defaults and status codes of the first-fit aligned allocator.
`default_nettype none
package ffaa_pkg;

	localparam int unsigned DEF_MAX_BLOCKS   = 64;
	localparam int unsigned DEF_HEADER_BYTES = 16;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ALIGN_W = 16;

	typedef enum logic [2:0] {
		ST_NEW      = 3'd0,
		ST_REUSED   = 3'd1,
		ST_RELEASED = 3'd2,
		ST_MARKED   = 3'd3,
		ST_NULL     = 3'd4,
		ST_NO_SPACE = 3'd5,
		ST_UNKNOWN  = 3'd6
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	// Request and response of the shared remainder unit.
	typedef struct packed {
		logic               start;
		logic [WORD_W-1:0]  dividend;
		logic [ALIGN_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic               done;
		logic [ALIGN_W-1:0] remainder;
	} mod_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/ffaa_mod_unit.sv */
// Bit-serial restoring remainder unit: 32-bit dividend modulo 16-bit divisor.
`default_nettype none
module ffaa_mod_unit import ffaa_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mod_req_t req,
	output mod_rsp_t      rsp
);

	logic [$clog2(WORD_W)-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [WORD_W-1:0]         dvd_q;
	logic [ALIGN_W-1:0]        div_q;
	logic [ALIGN_W-1:0]        rem_q;
	logic [ALIGN_W:0]          trial;
	logic [ALIGN_W-1:0]        rem_next;

	// Shift in one dividend bit, subtract the divisor when it fits.
	always_comb begin
		trial = {rem_q, dvd_q[WORD_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = ALIGN_W'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[ALIGN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(WORD_W))'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold operands; advance one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

/* rtl/core/first_fit_aligned_allocator_unit.sv */
// Top level of the first-fit aligned allocator: sequencer, block table and break.
//
// Allocates and frees blocks on a bump-pointer heap at heap_base. The block
// table lives in a memory with one write and one read port, walked one entry
// at a time through a read and an evaluate state. Every item passes through
// acceptance, dispatch and the loading of the result beat. An allocate adds
// the read and evaluate states per scanned entry, a serial remainder run for
// each free entry big enough to be an alignment candidate, a read state at
// the end of the table and, when a new block is placed at the break, the
// check, a remainder run, the end sum and the commit. The worst allocate walks
// a table of misaligned candidates, then places a new block. A free adds the
// read and evaluate states per entry walked up to the match plus one state to
// form the break address. Input is refused while an item is in progress; a
// result waits in the output register while the next item may be accepted.
// Table entries hold no reset state; only entries below the count are evaluated.
`default_nettype none
module first_fit_aligned_allocator_unit import ffaa_pkg::*; #(
	parameter int unsigned MAX_BLOCKS   = DEF_MAX_BLOCKS,
	parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // request_size[31:0], alignment[47:32], block_address[79:48]
	input  wire logic        s_tuser,  // operation
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // result_address
	output logic [2:0]       m_tuser   // status
);

	localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

	localparam logic [0:0] REG_HEAP_BASE  = 1'b0;
	localparam logic [0:0] REG_HEAP_LIMIT = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] addr;
		logic [WORD_W-1:0] size;
		logic              free;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_EVAL,
		S_MOD_REUSE,
		S_NEW_CHECK,
		S_MOD_NEW,
		S_NEW_END,
		S_NEW_COMMIT,
		S_BRK_OUT,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic [WORD_W-1:0]  heap_base_q;
	logic [WORD_W-1:0]  heap_limit_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [WORD_W-1:0]  brk_q;

	logic               op_q;
	logic [WORD_W-1:0]  size_q;
	logic [ALIGN_W-1:0] align_q;
	logic [WORD_W-1:0]  blk_q;

	logic [WORD_W:0]    pos_q;
	logic [WORD_W-1:0]  cand_addr_q;
	logic [WORD_W+1:0]  end_q;
	logic [WORD_W-1:0]  new_addr_q;

	logic [WORD_W-1:0]  res_addr_q;
	status_t            res_status_q;

	entry_t             mem [MAX_BLOCKS];
	entry_t             rd_q;
	logic               wr_en_q;
	logic               wr_set;
	logic [IDX_W-1:0]   wr_idx_q;
	entry_t             wr_data_q;

	mod_req_t           mod_req;
	mod_rsp_t           mod_rsp;

	logic [WORD_W:0]    drop;
	logic [ALIGN_W:0]   pad;

	ffaa_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Block table: one write, one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en_q) begin
			mem[wr_idx_q] <= wr_data_q;
		end
		rd_q <= mem[idx_q[IDX_W-1:0]];
	end

	assign drop = {1'b0, rd_q.size} + (WORD_W+1)'(HEADER_BYTES);
	assign pad  = (mod_rsp.remainder != '0) ?
		({1'b0, align_q} - {1'b0, mod_rsp.remainder}) : '0;

	// Start the remainder unit on a reuse candidate or on the break plus the header.
	always_comb begin
		mod_req.start    = 1'b0;
		mod_req.dividend = rd_q.addr;
		mod_req.divisor  = align_q;
		if (state_q == S_SCAN_EVAL && op_q == OP_ALLOC && rd_q.free &&
				rd_q.size >= size_q) begin
			mod_req.start = 1'b1;
		end else if (state_q == S_NEW_CHECK && count_q != CNT_W'(MAX_BLOCKS)) begin
			mod_req.start    = 1'b1;
			mod_req.dividend = heap_base_q + WORD_W'(brk_q + WORD_W'(HEADER_BYTES));
		end
	end

	// Flag the states that write one table entry.
	always_comb begin
		case (state_q)
			S_SCAN_EVAL:  wr_set = (op_q == OP_FREE) && (rd_q.addr == blk_q) &&
				(idx_q + 1'b1 != count_q);
			S_MOD_REUSE:  wr_set = mod_rsp.done && (mod_rsp.remainder == '0);
			S_NEW_COMMIT: wr_set = !(end_q > (WORD_W+2)'(heap_limit_q));
			default:      wr_set = 1'b0;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	// Sequencer, break, count, config and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_base_q  <= '0;
			heap_limit_q <= 32'd1048576;
			count_q      <= '0;
			idx_q        <= '0;
			brk_q        <= '0;
			wr_en_q      <= 1'b0;
			m_tvalid     <= 1'b0;
		end else begin
			wr_en_q <= wr_set;
			if (cfg_we) begin
				case (cfg_index)
					REG_HEAP_BASE:  heap_base_q  <= cfg_wdata;
					REG_HEAP_LIMIT: heap_limit_q <= cfg_wdata;
					default:        heap_base_q  <= heap_base_q;
				endcase
			end
			if (m_tvalid && m_tready && state_q != S_EMIT) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					idx_q <= '0;
					if ((op_q == OP_ALLOC && (size_q == '0 || align_q == '0)) ||
							(op_q == OP_FREE && blk_q == '0)) begin
						res_addr_q   <= '0;
						res_status_q <= ST_NULL;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					if (idx_q == count_q) begin
						if (op_q == OP_ALLOC) begin
							state_q <= S_NEW_CHECK;
						end else begin
							res_addr_q   <= '0;
							res_status_q <= ST_UNKNOWN;
							state_q      <= S_EMIT;
						end
					end else begin
						state_q <= S_SCAN_EVAL;
					end
				end
				S_SCAN_EVAL: begin
					if (op_q == OP_ALLOC) begin
						if (rd_q.free && rd_q.size >= size_q) begin
							state_q <= S_MOD_REUSE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SCAN_RD;
						end
					end else if (rd_q.addr == blk_q) begin
						// Last block goes back to the break; others are marked.
						if (idx_q + 1'b1 == count_q) begin
							brk_q        <= (drop > {1'b0, brk_q}) ? '0 :
								WORD_W'({1'b0, brk_q} - drop);
							count_q      <= count_q - 1'b1;
							res_status_q <= ST_RELEASED;
						end else begin
							wr_idx_q     <= idx_q[IDX_W-1:0];
							wr_data_q    <= '{addr: rd_q.addr, size: rd_q.size, free: 1'b1};
							res_status_q <= ST_MARKED;
						end
						state_q <= S_BRK_OUT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_MOD_REUSE: begin
					if (mod_rsp.done) begin
						if (mod_rsp.remainder == '0) begin
							wr_idx_q     <= idx_q[IDX_W-1:0];
							wr_data_q    <= '{addr: rd_q.addr, size: rd_q.size, free: 1'b0};
							res_addr_q   <= rd_q.addr;
							res_status_q <= ST_REUSED;
							state_q      <= S_EMIT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_NEW_CHECK: begin
					if (count_q == CNT_W'(MAX_BLOCKS)) begin
						res_addr_q   <= '0;
						res_status_q <= ST_NO_SPACE;
						state_q      <= S_EMIT;
					end else begin
						pos_q       <= {1'b0, brk_q} + (WORD_W+1)'(HEADER_BYTES);
						cand_addr_q <= mod_req.dividend;
						state_q     <= S_MOD_NEW;
					end
				end
				S_MOD_NEW: begin
					if (mod_rsp.done) begin
						state_q <= S_NEW_END;
					end
				end
				S_NEW_END: begin
					end_q      <= {1'b0, pos_q} + (WORD_W+2)'(pad) + (WORD_W+2)'(size_q);
					new_addr_q <= cand_addr_q + WORD_W'(pad);
					state_q    <= S_NEW_COMMIT;
				end
				S_NEW_COMMIT: begin
					if (end_q > (WORD_W+2)'(heap_limit_q)) begin
						res_addr_q   <= '0;
						res_status_q <= ST_NO_SPACE;
					end else begin
						wr_idx_q     <= count_q[IDX_W-1:0];
						wr_data_q    <= '{addr: new_addr_q, size: size_q, free: 1'b0};
						count_q      <= count_q + 1'b1;
						brk_q        <= end_q[WORD_W-1:0];
						res_addr_q   <= new_addr_q;
						res_status_q <= ST_NEW;
					end
					state_q <= S_EMIT;
				end
				S_BRK_OUT: begin
					res_addr_q <= heap_base_q + brk_q;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the request beat; load the result beat.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			op_q    <= s_tuser;
			size_q  <= s_tdata[31:0];
			align_q <= s_tdata[47:32];
			blk_q   <= s_tdata[79:48];
		end
		if (state_q == S_EMIT && (!m_tvalid || m_tready)) begin
			m_tdata <= res_addr_q;
			m_tuser <= res_status_q;
		end
	end

endmodule
`default_nettype wire

/* tb/sv/first_fit_aligned_allocator_unit_tb.sv */
// Self-checking testbench of the first-fit aligned allocator: directed table, random traffic.
`default_nettype none
module first_fit_aligned_allocator_unit_tb import ffaa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned HDR         = 16;
	localparam int unsigned IDLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_ITEMS = 1500;
	localparam logic        REG_BASE    = 1'b0;
	localparam logic        REG_LIMIT   = 1'b1;

	typedef struct packed {
		op_t         op;
		logic [31:0] size;
		logic [15:0] align;
		logic [31:0] addr;
	} request_t;

	typedef struct packed {
		logic [31:0] addr;
		status_t     status;
	} outcome_t;

	// directed row: request plus optional typed-in result
	typedef struct {
		request_t req;
		logic     fixed;
		outcome_t want;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	first_fit_aligned_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor state of the heap
	logic [31:0] heap_base_q;
	logic [31:0] heap_limit_q;
	logic [31:0] blk_addr [TABLE_DEPTH];
	logic [31:0] blk_size [TABLE_DEPTH];
	logic        blk_free [TABLE_DEPTH];
	int unsigned blk_count;
	logic [31:0] brk_off;

	outcome_t pending_results[$];
	int unsigned error_count;
	int unsigned idle_cycles;
	int unsigned rx_pause;
	bit          hold_off;
	bit          stall_enable;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic outcome_t predict_allocation(input request_t r);
		outcome_t o;
		logic [63:0] pos, pad, fin;
		logic [31:0] a, rem;
		o = '{addr: 32'd0, status: ST_NULL};
		if (r.op == OP_ALLOC) begin
			if (r.size == 0 || r.align == 0)
				return o;
			for (int i = 0; i < blk_count; i++) begin
				if (blk_free[i] && blk_size[i] >= r.size && blk_addr[i] % r.align == 0) begin
					blk_free[i] = 1'b0;
					return '{addr: blk_addr[i], status: ST_REUSED};
				end
			end
			o.status = ST_NO_SPACE;
			if (blk_count >= TABLE_DEPTH)
				return o;
			pos = 64'(brk_off) + HDR;
			a = 32'(64'(heap_base_q) + pos);
			rem = a % r.align;
			pad = (rem != 0) ? 64'(r.align) - rem : 64'd0;
			fin = pos + pad + r.size;
			if (fin > 64'(heap_limit_q))
				return o;
			a = 32'(64'(heap_base_q) + pos + pad);
			blk_addr[blk_count] = a;
			blk_size[blk_count] = r.size;
			blk_free[blk_count] = 1'b0;
			blk_count++;
			brk_off = fin[31:0];
			return '{addr: a, status: ST_NEW};
		end
		if (r.addr == 0)
			return o;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_addr[i] == r.addr) begin
				if (i + 1 == blk_count) begin
					fin = 64'(blk_size[i]) + HDR;
					brk_off = (fin > 64'(brk_off)) ? 32'd0 : brk_off - fin[31:0];
					blk_count--;
					return '{addr: heap_base_q + brk_off, status: ST_RELEASED};
				end
				blk_free[i] = 1'b1;
				return '{addr: heap_base_q + brk_off, status: ST_MARKED};
			end
		end
		return '{addr: 32'd0, status: ST_UNKNOWN};
	endfunction

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		outcome_t w;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, 32'd0);
			end else begin
				w = pending_results.pop_front();
				if (m_tdata !== w.addr)
					report_mismatch("result_address", m_tdata, w.addr);
				if (m_tuser !== w.status)
					report_mismatch("status", 32'(m_tuser), 32'(w.status));
			end
		end
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int unsigned gap_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// receiver stalls: mostly short, now and then a long pause, plus the hold-off
	always @(negedge clk) begin
		if (!arst_n || hold_off)
			m_tready <= 1'b0;
		else if (!stall_enable)
			m_tready <= 1'b1;
		else if (rx_pause != 0) begin
			m_tready <= 1'b0;
			rx_pause <= rx_pause - 1;
		end else if ($urandom_range(0, 199) == 0) begin
			m_tready <= 1'b0;
			rx_pause <= $urandom_range(10, 80);
		end else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	task automatic write_register(input logic idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_BASE)
			heap_base_q = val;
		else
			heap_limit_q = val;
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// offer one beat and wait for acceptance
	task automatic send_request(input request_t r, input bit fixed, input outcome_t want);
		int unsigned gap;
		outcome_t o;
		gap = gap_length();
		// wait for a falling edge first so valid is not dropped and raised in the same step
		repeat (gap + 1) @(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= r.op;
		s_tdata <= {r.addr, r.align, r.size};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		o = predict_allocation(r);
		if (fixed && o !== want)
			report_mismatch("directed row", 32'(o), 32'(want));
		pending_results.push_back(o);
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic request_t alloc_req(input logic [31:0] sz, input logic [15:0] al);
		return '{op: OP_ALLOC, size: sz, align: al, addr: $urandom()};
	endfunction

	function automatic request_t free_req(input logic [31:0] a);
		return '{op: OP_FREE, size: $urandom(), align: 16'($urandom()), addr: a};
	endfunction

	// pick a freeable address: mostly a live block, sometimes noise
	function automatic logic [31:0] pick_address();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (blk_count != 0 && roll < 60)
			return blk_addr[blk_count - 1];
		if (blk_count != 0 && roll < 90)
			return blk_addr[$urandom_range(0, blk_count - 1)];
		if (roll < 95)
			return 32'd0;
		return $urandom();
	endfunction

	function automatic request_t random_request();
		int unsigned roll;
		logic [15:0] al;
		roll = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: al = 16'($urandom());
			1: al = 16'hffff;
			2: al = 16'd0;
			default: al = 16'(1 << $urandom_range(0, 6));
		endcase
		if (roll < 50) begin
			if ($urandom_range(0, 19) == 0)
				return alloc_req($urandom(), al);
			return alloc_req($urandom_range(1, 300), al);
		end
		return free_req(pick_address());
	endfunction

	initial begin
		directed_row_t rows[$];
		request_t r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_ALLOC;
		m_tready = 1'b0;
		hold_off = 1'b0;
		stall_enable = 1'b1;
		rx_pause = 0;
		error_count = 0;
		idle_cycles = 0;
		heap_base_q = 32'd0;
		heap_limit_q = 32'd1048576;
		blk_count = 0;
		brk_off = 32'd0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed rows; values typed in only where obvious
		rows.push_back('{alloc_req(32'd0, 16'd8), 1'b1, '{32'd0, ST_NULL}});
		rows.push_back('{alloc_req(32'd8, 16'd0), 1'b1, '{32'd0, ST_NULL}});
		rows.push_back('{free_req(32'd0), 1'b1, '{32'd0, ST_NULL}});
		rows.push_back('{free_req(32'hffffffff), 1'b1, '{32'd0, ST_UNKNOWN}});
		rows.push_back('{alloc_req(32'hffffffff, 16'hffff), 1'b1, '{32'd0, ST_NO_SPACE}});
		rows.push_back('{alloc_req(32'd16, 16'd1), 1'b1, '{32'd16, ST_NEW}});
		rows.push_back('{alloc_req(32'd100, 16'd64), 1'b1, '{32'd64, ST_NEW}});
		rows.push_back('{alloc_req(32'd40, 16'hffff), 1'b0, '{32'd0, ST_NULL}});
		rows.push_back('{free_req(32'd16), 1'b0, '{32'd0, ST_NULL}});
		rows.push_back('{free_req(32'd16), 1'b0, '{32'd0, ST_NULL}});
		rows.push_back('{alloc_req(32'd8, 16'd16), 1'b0, '{32'd0, ST_NULL}});
		rows.push_back('{alloc_req(32'd8, 16'd32), 1'b0, '{32'd0, ST_NULL}});
		rows.push_back('{free_req(32'd64), 1'b0, '{32'd0, ST_NULL}});
		rows.push_back('{free_req(32'd17), 1'b0, '{32'd0, ST_NULL}});
		rows.push_back('{alloc_req(32'd1048576, 16'd1), 1'b0, '{32'd0, ST_NULL}});
		foreach (rows[i])
			send_request(rows[i].req, rows[i].fixed, rows[i].want);
		drain_results();

		// allocate two more blocks than the table holds, to fill it to its end
		write_register(REG_LIMIT, 32'hffffffff);
		write_register(REG_BASE, 32'hfffff000);
		for (int i = 0; i < TABLE_DEPTH + 2; i++)
			send_request(alloc_req($urandom_range(1, 200), 16'(1 << $urandom_range(0, 4))),
				1'b0, '{32'd0, ST_NULL});
		// long receiver hold-off while the sender keeps offering
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 8; i++)
				send_request(free_req(pick_address()), 1'b0, '{32'd0, ST_NULL});
		join
		drain_results();

		// random phases under several register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_register(REG_BASE, 32'd0); write_register(REG_LIMIT, 32'd0); end
				1: begin write_register(REG_BASE, $urandom()); write_register(REG_LIMIT, 32'd4096); end
				2: begin write_register(REG_BASE, 32'hffffffff); write_register(REG_LIMIT, 32'hffffffff); end
				3: begin write_register(REG_BASE, 32'h1000); write_register(REG_LIMIT, 32'd1048576); end
				default: begin write_register(REG_BASE, $urandom()); write_register(REG_LIMIT, $urandom()); end
			endcase
			stall_enable = (ph != 3);
			for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
				r = random_request();
				send_request(r, 1'b0, '{32'd0, ST_NULL});
				if ($urandom_range(0, 149) == 0)
					drain_results();
			end
			drain_results();
		end

		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire

/* first_fit_aligned_allocator_unit.f */
rtl/core/ffaa_pkg.sv
rtl/core/ffaa_mod_unit.sv
rtl/core/first_fit_aligned_allocator_unit.sv
tb/sv/first_fit_aligned_allocator_unit_tb.sv
